[sv/open_addressing_hash_table_defines.svh]
// Assertion macros used by the hash table top level.
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define OAHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define OAHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/oaht_pkg.sv]
// Shared types and codes for the open addressing hash table.
`timescale 1ns / 1ps

package oaht_pkg;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_REMOVE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_EXISTS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;    // clear one flag entry and step the sweep counter
        logic load;     // capture a request and set up the first probe
        logic advance;  // move to the next probe slot
        logic finish;   // commit writes and load the result
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last; // sweep counter is on the last entry
        logic done;       // probe stopped or no step left
    } ctl_sts_t;

endpackage

[sv/open_addressing_hash_table.sv]
// Top level of the open addressing hash table: controller, datapath and checks.
`timescale 1ns / 1ps
`include "open_addressing_hash_table_defines.svh"

// Key/value hash table held in 2^SLOTS_LOG2 slots, of which the first 2^slots_log2
// are in use (values of slots_log2 above SLOTS_LOG2 act as SLOTS_LOG2). Each request
// beat names an operation, a key, the key's precomputed hash and a value; probing
// starts at the masked hash, the first step is the table size minus one and each
// later step is one smaller, and it stops at a slot never used, at a slot that
// holds the same key or when no step is left. Removal leaves the key behind as a
// tombstone. Every request gives one result beat with a status, a value and the
// live entry count. One request is in work at a time: every probe is a registered
// read of the slot memories (state S_PROBE) followed by a key compare (S_CHECK),
// and the next request is only taken once the result is loaded. A worst case walk
// visits every slot in use. A new request is taken while the previous result still
// waits to be collected. After reset the block clears the slot flags, one entry a
// cycle, through all 2^SLOTS_LOG2 entries before it takes its first request; the
// size register may be written meanwhile.
module open_addressing_hash_table #(
    parameter int SLOTS_LOG2 = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] key,
    input  logic [31:0] key_hash,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [10:0] entry_count
);
    import oaht_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    // The controller sequences the clearing sweep and the probes and owns both
    // handshakes; the datapath holds the memories and works out each result.
    oaht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    oaht_datapath #(
        .SLOTS_LOG2 (SLOTS_LOG2)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .key         (key),
        .key_hash    (key_hash),
        .value       (value),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    // A result is only loaded when the output register is free.
    `OAHT_ASSERT_IMP(a_finish_free, ctl.finish, !out_valid || out_ready, "result overwritten")
    // Results are only committed once probing has come to an end.
    `OAHT_ASSERT_IMP(a_finish_done, ctl.finish, sts.done, "result before probe end")
    // Only one request is in work: acceptance drops the input ready.
    `OAHT_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second request taken")
    // Requests are never taken during the clearing sweep.
    `OAHT_ASSERT_IMP(a_no_load_clear, ctl.clear, !ctl.load && !in_ready, "request during clear")

endmodule

[sv/oaht_ctrl.sv]
// Controller state machine for the hash table: clearing sweep, probe sequencing, handshakes.
`timescale 1ns / 1ps

module oaht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    input  oaht_pkg::ctl_sts_t sts,
    output oaht_pkg::ctl_cmd_t ctl,
    output logic              in_ready,
    output logic              out_valid
);
    import oaht_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_CHECK
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!sts.done)
                begin
                    ctl.advance = 1'b1;
                    state_next  = S_PROBE;
                end
                else if (out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        in_ready_next  = (state_next == S_IDLE);
        out_valid_next = ctl.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

[sv/oaht_datapath.sv]
// Datapath for the hash table: slot memories, probe index, size register and result registers.
`timescale 1ns / 1ps

module oaht_datapath #(
    parameter int SLOTS_LOG2 = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  oaht_pkg::ctl_cmd_t ctl,
    output oaht_pkg::ctl_sts_t sts,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic [2:0]         cmd,
    input  logic [31:0]        key,
    input  logic [31:0]        key_hash,
    input  logic [31:0]        value,
    output logic [1:0]         status,
    output logic [31:0]        value_out,
    output logic [10:0]        entry_count
);
    import oaht_pkg::*;

    localparam int AW    = SLOTS_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(SLOTS_LOG2 + 1);
    localparam int CW    = AW + 1;

    // Flags are {used, present}; the key/value word is {key, value}.
    logic [1:0]  flag_mem [DEPTH];
    logic [63:0] kv_mem   [DEPTH];
    logic [1:0]  flag_rd_reg;
    logic [63:0] kv_rd_reg;

    logic [NW-1:0] size_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] step_reg, step_next;
    logic [AW-1:0] mask_reg;
    logic [AW:0]   span;
    logic [AW-1:0] mask_c;
    logic [2:0]    cmd_reg;
    logic [31:0]   key_reg;
    logic [31:0]   value_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   vout_reg, vout_next;

    logic          slot_used, slot_present, key_match, cmd_ok, stop;
    logic          flag_we, kv_we;
    logic [1:0]    flag_wdata;
    logic [AW-1:0] flag_addr;

    // Log2 of the effective table size, saturated at that of the store depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= NW'(SLOTS_LOG2);
        end
        else if (cfg_we)
        begin
            size_reg <= ({1'b0, cfg_wdata} > 5'(SLOTS_LOG2)) ? NW'(SLOTS_LOG2)
                                                             : NW'(cfg_wdata);
        end
    end

    assign span   = (AW + 1)'(1) << size_reg;
    assign mask_c = AW'(span - (AW + 1)'(1));

    // Probe decision on the registered read of the current slot.
    assign slot_used    = flag_rd_reg[1];
    assign slot_present = flag_rd_reg[0];
    assign key_match    = (kv_rd_reg[63:32] == key_reg);
    assign cmd_ok       = (cmd_reg <= CMD_REMOVE);
    assign stop         = !cmd_ok || !slot_used || key_match;

    assign sts.done       = stop || (step_reg == '0);
    assign sts.clear_last = (clr_reg == '1);

    always_comb
    begin
        status_next = ST_MISS;
        vout_next   = '0;
        count_next  = count_reg;
        flag_we     = 1'b0;
        flag_wdata  = 2'b11;
        kv_we       = 1'b0;
        case (cmd_t'(cmd_reg))
            CMD_LOOKUP:
            begin
                if (stop && slot_present)
                begin
                    status_next = ST_OK;
                    vout_next   = kv_rd_reg[31:0];
                end
            end
            CMD_INSERT:
            begin
                if (!stop)
                begin
                    status_next = ST_FULL;
                end
                else if (slot_present)
                begin
                    status_next = ST_EXISTS;
                    vout_next   = kv_rd_reg[31:0];
                end
                else
                begin
                    status_next = ST_OK;
                    count_next  = count_reg + CW'(1);
                    flag_we     = 1'b1;
                    kv_we       = 1'b1;
                end
            end
            CMD_UPDATE:
            begin
                if (stop && slot_present)
                begin
                    status_next = ST_OK;
                    kv_we       = 1'b1;
                end
            end
            CMD_ADD:
            begin
                if (!stop)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    if (!slot_present)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    flag_we = 1'b1;
                    kv_we   = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (stop && slot_present)
                begin
                    status_next = ST_OK;
                    flag_we     = 1'b1;
                    flag_wdata  = 2'b10;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        step_next = step_reg;
        if (ctl.load)
        begin
            idx_next  = key_hash[AW-1:0] & mask_c;
            step_next = mask_c;
        end
        else if (ctl.advance)
        begin
            idx_next  = (idx_reg + step_reg) & mask_reg;
            step_next = step_reg - AW'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctl.clear)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (ctl.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        step_reg <= step_next;
        if (ctl.load)
        begin
            mask_reg  <= mask_c;
            cmd_reg   <= cmd;
            key_reg   <= key;
            value_reg <= value;
        end
        if (ctl.finish)
        begin
            status_reg <= status_next;
            vout_reg   <= vout_next;
        end
    end

    assign flag_addr = ctl.clear ? clr_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            flag_mem[flag_addr] <= 2'b00;
        end
        else if (ctl.finish && flag_we)
        begin
            flag_mem[flag_addr] <= flag_wdata;
        end
        flag_rd_reg <= flag_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish && kv_we)
        begin
            kv_mem[idx_reg] <= {key_reg, value_reg};
        end
        kv_rd_reg <= kv_mem[idx_reg];
    end

    assign status      = status_reg;
    assign value_out   = vout_reg;
    assign entry_count = 11'(count_reg);

endmodule
